// File: design/rgb_yuv_luma_halving_assert.svh
// assertion macros shared by the luma halving pipeline modules
`ifndef RGB_YUV_LUMA_HALVING_ASSERT_SVH
`define RGB_YUV_LUMA_HALVING_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RGBYL_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgbyl assertion failed");

// next-cycle implication, disabled while in reset
`define RGBYL_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgbyl assertion failed");

`endif

// File: design/rgbyl_pkg.sv
// shared constants and payload types for the luma halving pipeline
package rgbyl_pkg;

  localparam int unsigned COEF_FRAC_BITS = 16;
  // widest coefficient is 1/0.493, just above two
  localparam int unsigned CW = COEF_FRAC_BITS + 2;

  localparam logic [CW-1:0] W_RED   = CW'(((64'd3 << COEF_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [CW-1:0] W_GREEN = CW'(((64'd59 << COEF_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [CW-1:0] W_BLUE  = CW'(((64'd11 << COEF_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [CW-1:0] K_U     = CW'(((64'd493 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] K_V     = CW'(((64'd877 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] INV_U   = CW'(((64'd1000 << COEF_FRAC_BITS) + 64'd246) / 64'd493);
  localparam logic [CW-1:0] INV_V   = CW'(((64'd1000 << COEF_FRAC_BITS) + 64'd438) / 64'd877);
  localparam logic [CW-1:0] INV_G   = CW'(((64'd100 << COEF_FRAC_BITS) + 64'd29) / 64'd59);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_t;

  typedef struct packed {
    logic [7:0]        luma;
    logic signed [7:0] chroma_u;
    logic signed [7:0] chroma_v;
    logic              frame_end;
  } yuv_t;

  typedef struct packed {
    logic [7:0]        luma;
    logic signed [7:0] chroma_u;
    logic signed [7:0] chroma_v;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              frame_end;
  } res_t;

endpackage

// File: design/rgbyl_in_if.sv
// pixel input channel
interface rgbyl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_end_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_end_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input frame_end_in, output ready);
endinterface

// File: design/rgbyl_out_if.sv
// result channel: luma, chroma and adjusted pixel
interface rgbyl_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        luma;
  logic signed [7:0] chroma_u;
  logic signed [7:0] chroma_v;
  logic [7:0]        red_out;
  logic [7:0]        green_out;
  logic [7:0]        blue_out;
  logic              frame_end_out;

  modport source (output valid, output luma, output chroma_u, output chroma_v,
                  output red_out, output green_out, output blue_out,
                  output frame_end_out, input ready);
  modport sink (input valid, input luma, input chroma_u, input chroma_v,
                input red_out, input green_out, input blue_out,
                input frame_end_out, output ready);
endinterface

// File: design/rgbyl_fwd.sv
// forward conversion pipeline: rgb to luma and saturated chroma, four stages
`include "rgb_yuv_luma_halving_assert.svh"

module rgbyl_fwd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rgbyl_pkg::rgb_t in_pix,
  output logic          out_valid,
  input  logic          out_ready,
  output rgbyl_pkg::yuv_t out_yuv
);
  import rgbyl_pkg::*;

  localparam int unsigned NS = 4;
  localparam int unsigned PW = 8 + CW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned MW = 9 + CW;
  localparam int unsigned QW = MW - COEF_FRAC_BITS;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  // a stage loads when it is empty or its successor loads
  assign adv[3]    = !vld_r[3] || out_ready;
  assign adv[2]    = !vld_r[2] || adv[3];
  assign adv[1]    = !vld_r[1] || adv[2];
  assign adv[0]    = !vld_r[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
    end
  end

  // stage 0: weighted components
  logic [PW-1:0] pr0_r, pg0_r, pb0_r;
  logic [7:0]    red0_r, blue0_r;
  logic          fe0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pr0_r   <= PW'(in_pix.red) * PW'(W_RED);
      pg0_r   <= PW'(in_pix.green) * PW'(W_GREEN);
      pb0_r   <= PW'(in_pix.blue) * PW'(W_BLUE);
      red0_r  <= in_pix.red;
      blue0_r <= in_pix.blue;
      fe0_r   <= in_pix.frame_end;
    end
  end

  // stage 1: luma sum, integer part capped at 255
  logic [SW-1:0] ysum_nxt, yq_nxt;
  logic [7:0]    y_nxt;
  logic [7:0]    y1_r, red1_r, blue1_r;
  logic          fe1_r;

  always_comb begin
    ysum_nxt = SW'(pr0_r) + SW'(pg0_r) + SW'(pb0_r);
    yq_nxt   = ysum_nxt >> COEF_FRAC_BITS;
    y_nxt    = (yq_nxt > SW'(255)) ? 8'd255 : yq_nxt[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      y1_r    <= y_nxt;
      red1_r  <= red0_r;
      blue1_r <= blue0_r;
      fe1_r   <= fe0_r;
    end
  end

  // stage 2: color differences as sign and magnitude, scaled
  logic [8:0]    du_nxt, dv_nxt, mu_nxt, mv_nxt;
  logic [MW-1:0] mu2_r, mv2_r;
  logic          su2_r, sv2_r;
  logic [7:0]    y2_r;
  logic          fe2_r;

  always_comb begin
    du_nxt = {1'b0, blue1_r} - {1'b0, y1_r};
    dv_nxt = {1'b0, red1_r} - {1'b0, y1_r};
    mu_nxt = du_nxt[8] ? (9'd0 - du_nxt) : du_nxt;
    mv_nxt = dv_nxt[8] ? (9'd0 - dv_nxt) : dv_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      mu2_r <= MW'(mu_nxt) * MW'(K_U);
      mv2_r <= MW'(mv_nxt) * MW'(K_V);
      su2_r <= du_nxt[8];
      sv2_r <= dv_nxt[8];
      y2_r  <= y1_r;
      fe2_r <= fe1_r;
    end
  end

  // stage 3: truncate toward zero, restore sign, saturate to 8 bits
  logic [QW-1:0]     qu_nxt, qv_nxt, nqu_nxt, nqv_nxt;
  logic signed [7:0] u_nxt, v_nxt;
  logic signed [7:0] u3_r, v3_r;
  logic [7:0]        y3_r;
  logic              fe3_r;

  always_comb begin
    qu_nxt  = mu2_r[MW-1:COEF_FRAC_BITS];
    qv_nxt  = mv2_r[MW-1:COEF_FRAC_BITS];
    nqu_nxt = -qu_nxt;
    nqv_nxt = -qv_nxt;
    if (su2_r) begin
      u_nxt = (qu_nxt > QW'(128)) ? 8'sh80 : $signed(nqu_nxt[7:0]);
    end else begin
      u_nxt = (qu_nxt > QW'(127)) ? 8'sh7f : $signed(qu_nxt[7:0]);
    end
    if (sv2_r) begin
      v_nxt = (qv_nxt > QW'(128)) ? 8'sh80 : $signed(nqv_nxt[7:0]);
    end else begin
      v_nxt = (qv_nxt > QW'(127)) ? 8'sh7f : $signed(qv_nxt[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      u3_r  <= u_nxt;
      v3_r  <= v_nxt;
      y3_r  <= y2_r;
      fe3_r <= fe2_r;
    end
  end

  always_comb begin
    out_yuv.luma      = y3_r;
    out_yuv.chroma_u  = u3_r;
    out_yuv.chroma_v  = v3_r;
    out_yuv.frame_end = fe3_r;
  end

  `RGBYL_ASSERT_NEXT(a_fwd_take, clk, rst_n, in_valid && in_ready, vld_r[0])
  // scaled chroma magnitude never exceeds the 8-bit difference range
  `RGBYL_ASSERT_IMPL(a_fwd_mag, clk, rst_n, vld_r[2], (qu_nxt < QW'(256)) && (qv_nxt < QW'(256)))

endmodule

// File: design/rgbyl_back.sv
// back conversion pipeline: halved luma and chroma to saturated rgb, six stages
`include "rgb_yuv_luma_halving_assert.svh"

module rgbyl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rgbyl_pkg::yuv_t in_yuv,
  output logic            out_valid,
  input  logic            out_ready,
  output rgbyl_pkg::res_t out_res
);
  import rgbyl_pkg::*;

  localparam int unsigned NS  = 6;
  localparam int unsigned PV  = CW + 9;
  localparam int unsigned SW  = COEF_FRAC_BITS + 12;
  localparam int unsigned GW  = COEF_FRAC_BITS + 7;
  localparam int unsigned PRW = 8 + CW;
  localparam int unsigned HW  = GW + CW;
  localparam int unsigned GQW = HW - 2 * COEF_FRAC_BITS;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  assign adv[5]    = !vld_r[5] || out_ready;
  assign adv[4]    = !vld_r[4] || adv[5];
  assign adv[3]    = !vld_r[3] || adv[4];
  assign adv[2]    = !vld_r[2] || adv[3];
  assign adv[1]    = !vld_r[1] || adv[2];
  assign adv[0]    = !vld_r[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
      if (adv[4]) vld_r[4] <= vld_r[3];
      if (adv[5]) vld_r[5] <= vld_r[4];
    end
  end

  logic signed [CW:0] inv_u_s, inv_v_s;
  assign inv_u_s = $signed({1'b0, INV_U});
  assign inv_v_s = $signed({1'b0, INV_V});

  // stage 0: chroma times reciprocal weights
  logic signed [PV-1:0] pu0_r, pv0_r;
  logic [6:0]           yh0_r;
  logic [7:0]           y0_r;
  logic signed [7:0]    u0_r, v0_r;
  logic                 fe0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pu0_r <= PV'($signed(in_yuv.chroma_u)) * PV'(inv_u_s);
      pv0_r <= PV'($signed(in_yuv.chroma_v)) * PV'(inv_v_s);
      yh0_r <= in_yuv.luma[7:1];
      y0_r  <= in_yuv.luma;
      u0_r  <= in_yuv.chroma_u;
      v0_r  <= in_yuv.chroma_v;
      fe0_r <= in_yuv.frame_end;
    end
  end

  // stage 1: add halved luma, clamp red and blue to [0, 255]
  logic [SW-1:0] base0_nxt, sr_nxt, sb_nxt;
  logic [7:0]    ro_nxt, bo_nxt;
  logic [7:0]    ro1_r, bo1_r, y1_r;
  logic [6:0]    yh1_r;
  logic signed [7:0] u1_r, v1_r;
  logic          fe1_r;

  always_comb begin
    base0_nxt = {{(SW - COEF_FRAC_BITS - 7){1'b0}}, yh0_r, {COEF_FRAC_BITS{1'b0}}};
    sr_nxt    = base0_nxt + {{(SW - PV){pv0_r[PV-1]}}, pv0_r};
    sb_nxt    = base0_nxt + {{(SW - PV){pu0_r[PV-1]}}, pu0_r};
    if (sr_nxt[SW-1]) begin
      ro_nxt = 8'd0;
    end else if (|sr_nxt[SW-2:COEF_FRAC_BITS+8]) begin
      ro_nxt = 8'd255;
    end else begin
      ro_nxt = sr_nxt[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    if (sb_nxt[SW-1]) begin
      bo_nxt = 8'd0;
    end else if (|sb_nxt[SW-2:COEF_FRAC_BITS+8]) begin
      bo_nxt = 8'd255;
    end else begin
      bo_nxt = sb_nxt[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ro1_r <= ro_nxt;
      bo1_r <= bo_nxt;
      yh1_r <= yh0_r;
      y1_r  <= y0_r;
      u1_r  <= u0_r;
      v1_r  <= v0_r;
      fe1_r <= fe0_r;
    end
  end

  // stage 2: weigh the clamped red and blue
  logic [PRW-1:0]    qr2_r, qb2_r;
  logic [7:0]        ro2_r, bo2_r, y2_r;
  logic [6:0]        yh2_r;
  logic signed [7:0] u2_r, v2_r;
  logic              fe2_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      qr2_r <= PRW'(ro1_r) * PRW'(W_RED);
      qb2_r <= PRW'(bo1_r) * PRW'(W_BLUE);
      ro2_r <= ro1_r;
      bo2_r <= bo1_r;
      yh2_r <= yh1_r;
      y2_r  <= y1_r;
      u2_r  <= u1_r;
      v2_r  <= v1_r;
      fe2_r <= fe1_r;
    end
  end

  // stage 3: green numerator; a nonnegative value is at most yh << frac
  logic [SW-1:0]     num_nxt;
  logic [GW-1:0]     nm3_r;
  logic              neg3_r;
  logic [7:0]        ro3_r, bo3_r, y3_r;
  logic signed [7:0] u3_r, v3_r;
  logic              fe3_r;

  always_comb begin
    num_nxt = {{(SW - COEF_FRAC_BITS - 7){1'b0}}, yh2_r, {COEF_FRAC_BITS{1'b0}}}
              - SW'(qr2_r) - SW'(qb2_r);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      neg3_r <= num_nxt[SW-1];
      nm3_r  <= num_nxt[GW-1:0];
      ro3_r  <= ro2_r;
      bo3_r  <= bo2_r;
      y3_r   <= y2_r;
      u3_r   <= u2_r;
      v3_r   <= v2_r;
      fe3_r  <= fe2_r;
    end
  end

  // stage 4: divide by the green weight
  logic [HW-1:0]     gp4_r;
  logic              neg4_r;
  logic [7:0]        ro4_r, bo4_r, y4_r;
  logic signed [7:0] u4_r, v4_r;
  logic              fe4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      gp4_r  <= HW'(nm3_r) * HW'(INV_G);
      neg4_r <= neg3_r;
      ro4_r  <= ro3_r;
      bo4_r  <= bo3_r;
      y4_r   <= y3_r;
      u4_r   <= u3_r;
      v4_r   <= v3_r;
      fe4_r  <= fe3_r;
    end
  end

  // stage 5: clamp green, output register
  logic [GQW-1:0]    gq_nxt;
  logic [7:0]        go_nxt;
  logic [7:0]        go5_r, ro5_r, bo5_r, y5_r;
  logic signed [7:0] u5_r, v5_r;
  logic              fe5_r;

  always_comb begin
    gq_nxt = gp4_r[HW-1:2*COEF_FRAC_BITS];
    if (neg4_r) begin
      go_nxt = 8'd0;
    end else if (|gq_nxt[GQW-1:8]) begin
      go_nxt = 8'd255;
    end else begin
      go_nxt = gq_nxt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      go5_r <= go_nxt;
      ro5_r <= ro4_r;
      bo5_r <= bo4_r;
      y5_r  <= y4_r;
      u5_r  <= u4_r;
      v5_r  <= v4_r;
      fe5_r <= fe4_r;
    end
  end

  always_comb begin
    out_res.luma      = y5_r;
    out_res.chroma_u  = u5_r;
    out_res.chroma_v  = v5_r;
    out_res.red       = ro5_r;
    out_res.green     = go5_r;
    out_res.blue      = bo5_r;
    out_res.frame_end = fe5_r;
  end

  // negative chroma can only pull a component below the halved luma
  `RGBYL_ASSERT_IMPL(a_back_red_le, clk, rst_n, vld_r[1] && v1_r[7], (ro1_r <= {1'b0, yh1_r}))
  `RGBYL_ASSERT_IMPL(a_back_blue_le, clk, rst_n, vld_r[1] && u1_r[7], (bo1_r <= {1'b0, yh1_r}))
  `RGBYL_ASSERT_NEXT(a_back_green_zero, clk, rst_n, vld_r[4] && adv[4] && neg4_r, go5_r == 8'd0)

endmodule

// File: design/rgb_yuv_luma_halving.sv
// top level: rgb to yuv, luma halving and back conversion
//
//   channel   dir  handshake      payload
//   in_pix    in   valid/ready    red_in, green_in, blue_in, frame_end_in
//   out_pix   out  valid/ready    luma, chroma_u, chroma_v, red_out, green_out,
//                                 blue_out, frame_end_out
//
// one pixel per clock sustained while out_pix.ready stays high
// (ten register stages: four forward, six back conversion)
// reset clears only the stage valid bits
// a stage holds only while it and every stage after it are full, so bubbles
// close up during an output stall and in_pix.ready stays high until all fill
module rgb_yuv_luma_halving (
  input logic        clk,
  input logic        rst_n,
  rgbyl_in_if.sink   in_pix,
  rgbyl_out_if.source out_pix
);
  import rgbyl_pkg::*;

  rgb_t pix;
  yuv_t yuv;
  res_t res;
  logic yuv_valid, yuv_ready;

  always_comb begin
    pix.red       = in_pix.red_in;
    pix.green     = in_pix.green_in;
    pix.blue      = in_pix.blue_in;
    pix.frame_end = in_pix.frame_end_in;
  end

  rgbyl_fwd u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_pix    (pix),
    .out_valid (yuv_valid),
    .out_ready (yuv_ready),
    .out_yuv   (yuv)
  );

  rgbyl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yuv_valid),
    .in_ready  (yuv_ready),
    .in_yuv    (yuv),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .out_res   (res)
  );

  always_comb begin
    out_pix.luma          = res.luma;
    out_pix.chroma_u      = res.chroma_u;
    out_pix.chroma_v      = res.chroma_v;
    out_pix.red_out       = res.red;
    out_pix.green_out     = res.green;
    out_pix.blue_out      = res.blue;
    out_pix.frame_end_out = res.frame_end;
  end

endmodule
